### src/hpsi_pkg.sv
`timescale 1ns / 1ps

package hpsi_pkg;

    // coordinate wrap range, a power of two so the wrap is a mask
    localparam int MAX_RESOLUTION = 128;
    localparam int COORD_W        = $clog2(MAX_RESOLUTION);

    // stream payload widths
    localparam int PIX_W      = 32;
    localparam int SAMPLE_W   = 32;
    localparam int IN_DATA_W  = 2 * PIX_W + SAMPLE_W;
    localparam int IDX_W      = 47;
    localparam int OUT_DATA_W = 48;

    // configuration register widths and limits
    localparam int EXP2_W   = 3;
    localparam int EXP3_W   = 3;
    localparam int INV2_W   = 7;
    localparam int INV3_W   = 8;
    localparam int EXP2_MAX = 7;
    localparam int EXP3_MAX = 5;

    // apb port
    localparam int ADDR_W  = 4;
    localparam int APB_W   = 32;
    localparam int REGSEL_W = 2;
    localparam logic [REGSEL_W-1:0] REG_EXP_TWO   = 2'd0;
    localparam logic [REGSEL_W-1:0] REG_EXP_THREE = 2'd1;
    localparam logic [REGSEL_W-1:0] REG_INV_TWO   = 2'd2;
    localparam logic [REGSEL_W-1:0] REG_INV_THREE = 2'd3;

    // datapath widths
    localparam int DIGITS3   = EXP3_MAX;
    localparam int REV2_W    = EXP2_MAX;
    localparam int REV3_W    = 8;
    localparam int SCALE3_W  = 8;
    localparam int STRIDE_W  = 15;
    localparam int X3_W      = REV3_W + INV3_W;
    localparam int T1_W      = STRIDE_W;
    localparam int SUM_W     = STRIDE_W + 1;
    localparam int MSH_W     = X3_W + SCALE3_W;

    // modulo reduction pipeline: restoring steps per stage
    localparam int STEPS_PER_STAGE = 2;
    localparam int MOD_STAGES      = X3_W / STEPS_PER_STAGE;

    // queue between front and back, power of two deep
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    // powers of three indexed by exponent
    typedef logic [EXP3_MAX:0][SCALE3_W-1:0] t_pow3_table;
    localparam t_pow3_table POW3_TABLE = {8'd243, 8'd81, 8'd27, 8'd9, 8'd3, 8'd1};

    // base-3 digits of every wrapped row, least significant digit lowest
    typedef logic [MAX_RESOLUTION-1:0][2*DIGITS3-1:0] t_digit_table;

    function automatic t_digit_table build_digit_table();
        t_digit_table tab;
        int           v;
        for (int n = 0; n < MAX_RESOLUTION; n++) begin
            v = n;
            for (int i = 0; i < DIGITS3; i++) begin
                tab[n][2*i +: 2] = 2'(v % 3);
                v = v / 3;
            end
        end
        return tab;
    endfunction

    localparam t_digit_table DIGIT_TABLE = build_digit_table();

    // derived configuration, exp_three already saturated
    typedef struct packed {
        logic [EXP2_W-1:0]   exp_two;
        logic [EXP3_W-1:0]   exp_three;
        logic [INV2_W-1:0]   inv_two;
        logic [INV3_W-1:0]   inv_three;
        logic [SCALE3_W-1:0] scale3;
        logic [REV2_W-1:0]   mask2;
        logic [STRIDE_W-1:0] stride;
    } t_cfg;

    // item after the front: reversed x, digits of y, sample number
    typedef struct packed {
        logic [REV2_W-1:0]    rev2;
        logic [2*DIGITS3-1:0] digits;
        logic [SAMPLE_W-1:0]  sample;
    } t_item;

endpackage

### src/hpsi_regs.sv
`timescale 1ns / 1ps

module hpsi_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpsi_pkg::ADDR_W-1:0]   paddr,
    input  logic [hpsi_pkg::APB_W-1:0]    pwdata,
    output logic [hpsi_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    output hpsi_pkg::t_cfg                o_cfg
);
    import hpsi_pkg::*;

    logic [EXP2_W-1:0]   r_exp_two;
    logic [EXP3_W-1:0]   r_exp_three;
    logic [INV2_W-1:0]   r_inv_two;
    logic [INV3_W-1:0]   r_inv_three;
    t_cfg                n_cfg;
    logic                w_wr;
    logic [REGSEL_W-1:0] w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_sel  = paddr[ADDR_W-1:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_two   <= '0;
            r_exp_three <= '0;
            r_inv_two   <= '0;
            r_inv_three <= '0;
        end else if (w_wr) begin
            case (w_sel)
                REG_EXP_TWO:   r_exp_two   <= pwdata[EXP2_W-1:0];
                REG_EXP_THREE: r_exp_three <= pwdata[EXP3_W-1:0];
                REG_INV_TWO:   r_inv_two   <= pwdata[INV2_W-1:0];
                REG_INV_THREE: r_inv_three <= pwdata[INV3_W-1:0];
                default: ;
            endcase
        end
    end

    // read back raw values
    always_comb begin
        case (w_sel)
            REG_EXP_TWO:   prdata = APB_W'(r_exp_two);
            REG_EXP_THREE: prdata = APB_W'(r_exp_three);
            REG_INV_TWO:   prdata = APB_W'(r_inv_two);
            REG_INV_THREE: prdata = APB_W'(r_inv_three);
            default:       prdata = '0;
        endcase
    end

    // power-of-three scale, stride and mask derived from the exponents
    always_comb begin
        n_cfg.exp_two   = r_exp_two;
        n_cfg.exp_three = (r_exp_three > EXP3_W'(EXP3_MAX)) ? EXP3_W'(EXP3_MAX) : r_exp_three;
        n_cfg.inv_two   = r_inv_two;
        n_cfg.inv_three = r_inv_three;
        n_cfg.scale3    = POW3_TABLE[n_cfg.exp_three];
        n_cfg.mask2     = REV2_W'((9'd1 << r_exp_two) - 9'd1);
        n_cfg.stride    = STRIDE_W'(n_cfg.scale3) << r_exp_two;
    end

    assign o_cfg = n_cfg;

endmodule

### src/hpsi_front.sv
`timescale 1ns / 1ps

module hpsi_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hpsi_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [hpsi_pkg::IN_DATA_W-1:0] i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output hpsi_pkg::t_item                o_item
);
    import hpsi_pkg::*;

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [PIX_W-1:0]  w_px;
    logic [PIX_W-1:0]  w_py;
    logic [REV2_W-1:0] w_rev;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // wrap coordinates, reverse x bits, look up base-3 digits of y
    always_comb begin
        w_px = i_data[PIX_W-1:0] & PIX_W'(MAX_RESOLUTION - 1);
        w_py = i_data[2*PIX_W-1:PIX_W] & PIX_W'(MAX_RESOLUTION - 1);
        for (int i = 0; i < REV2_W; i++) begin
            w_rev[i] = w_px[REV2_W-1-i];
        end
        n_item.rev2   = w_rev >> (EXP2_W'(EXP2_MAX) - i_cfg.exp_two);
        n_item.digits = DIGIT_TABLE[w_py[COORD_W-1:0]];
        n_item.sample = i_data[IN_DATA_W-1:2*PIX_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

### src/hpsi_queue.sv
`timescale 1ns / 1ps

module hpsi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  hpsi_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output hpsi_pkg::t_item o_item
);
    import hpsi_pkg::*;

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and fill level, pointers wrap by overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### src/hpsi_back.sv
`timescale 1ns / 1ps

module hpsi_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hpsi_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  hpsi_pkg::t_item                i_item,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [hpsi_pkg::IDX_W-1:0]     o_index
);
    import hpsi_pkg::*;

    localparam int HW = REV3_W + 2;

    logic                w_adv;

    // first stage: digit reversal of y, x term modulo 2^exp_two
    logic                r_b1_valid;
    logic [REV3_W-1:0]   r_b1_rev3;
    logic [REV2_W-1:0]   r_b1_p2;
    logic [SAMPLE_W-1:0] r_b1_smp;
    logic [REV3_W-1:0]   n_rev3;
    logic [REV2_W-1:0]   n_p2;

    // reduction pipeline, index 0 holds the products
    logic                r_mv   [MOD_STAGES+1];
    logic [X3_W-1:0]     r_mrem [MOD_STAGES+1];
    logic [T1_W-1:0]     r_mt1  [MOD_STAGES+1];
    logic [SAMPLE_W-1:0] r_msmp [MOD_STAGES+1];
    logic [X3_W-1:0]     n_mrem [MOD_STAGES+1];
    logic [T1_W-1:0]     n_t1;

    // combine and final correction
    logic                r_c_valid;
    logic [SUM_W-1:0]    r_c_sum;
    logic [IDX_W-1:0]    r_c_prod;
    logic                r_d_valid;
    logic [STRIDE_W-1:0] r_d_off;
    logic [IDX_W-1:0]    r_d_prod;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_idx;
    logic [SUM_W-1:0]    n_c_sum;
    logic [IDX_W-1:0]    n_c_prod;
    logic [STRIDE_W-1:0] n_d_off;

    // whole pipeline moves when the output register can take a new item
    assign w_adv   = !r_out_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_out_valid;
    assign o_index = r_out_idx;

    // base-3 reversal by horner over the live digits
    always_comb begin
        n_rev3 = '0;
        for (int i = 0; i < DIGITS3; i++) begin
            if (EXP3_W'(i) < i_cfg.exp_three) begin
                n_rev3 = REV3_W'((HW'(n_rev3) * HW'(3)) + HW'(i_item.digits[2*i +: 2]));
            end
        end
        n_p2 = REV2_W'(i_item.rev2 * i_cfg.inv_two) & i_cfg.mask2;
    end

    // products, then restoring reduction of the y term modulo 3^exp_three
    always_comb begin
        logic [X3_W-1:0]  rem;
        logic [MSH_W-1:0] shifted;
        n_mrem[0] = X3_W'(r_b1_rev3) * X3_W'(i_cfg.inv_three);
        n_t1      = T1_W'(r_b1_p2) * T1_W'(i_cfg.scale3);
        for (int j = 0; j < MOD_STAGES; j++) begin
            rem = r_mrem[j];
            for (int s = 0; s < STEPS_PER_STAGE; s++) begin
                shifted = MSH_W'(i_cfg.scale3) << (X3_W - 1 - (j * STEPS_PER_STAGE + s));
                if (MSH_W'(rem) >= shifted) begin
                    rem = rem - X3_W'(shifted);
                end
            end
            n_mrem[j+1] = rem;
        end
    end

    // sum of both terms, sample times stride, single subtract correction
    always_comb begin
        n_c_sum  = SUM_W'(r_mt1[MOD_STAGES]) + (SUM_W'(r_mrem[MOD_STAGES]) << i_cfg.exp_two);
        n_c_prod = IDX_W'(r_msmp[MOD_STAGES]) * IDX_W'(i_cfg.stride);
        if (r_c_sum >= SUM_W'(i_cfg.stride)) begin
            n_d_off = STRIDE_W'(r_c_sum - SUM_W'(i_cfg.stride));
        end else begin
            n_d_off = STRIDE_W'(r_c_sum);
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            for (int j = 0; j <= MOD_STAGES; j++) begin
                r_mv[j] <= 1'b0;
            end
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_b1_valid <= i_valid;
            r_mv[0]    <= r_b1_valid;
            for (int j = 0; j < MOD_STAGES; j++) begin
                r_mv[j+1] <= r_mv[j];
            end
            r_c_valid   <= r_mv[MOD_STAGES];
            r_d_valid   <= r_c_valid;
            r_out_valid <= r_d_valid;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b1_rev3 <= n_rev3;
            r_b1_p2   <= n_p2;
            r_b1_smp  <= i_item.sample;
            r_mrem[0] <= n_mrem[0];
            r_mt1[0]  <= n_t1;
            r_msmp[0] <= r_b1_smp;
            for (int j = 0; j < MOD_STAGES; j++) begin
                r_mrem[j+1] <= n_mrem[j+1];
                r_mt1[j+1]  <= r_mt1[j];
                r_msmp[j+1] <= r_msmp[j];
            end
            r_c_sum   <= n_c_sum;
            r_c_prod  <= n_c_prod;
            r_d_off   <= n_d_off;
            r_d_prod  <= r_c_prod;
            r_out_idx <= r_d_prod + IDX_W'(r_d_off);
        end
    end

endmodule

### src/halton_pixel_sample_index_top.sv
`timescale 1ns / 1ps

// Halton pixel sample index for bases 2 and 3. Each input item carries a pixel
// column, a pixel row (both signed, wrapped modulo MAX_RESOLUTION) and a sample
// number; the result item is that sample's global index, the pixel offset plus
// sample number times the stride 2^exp_two * 3^exp_three. Load exp_two,
// exp_three and the two modular inverses over APB before streaming items; an
// exp_three above five counts as five. One item is accepted every clock cycle
// unless an output stall has filled the queue. The front register hands each
// item to the four-entry queue, and the back pipeline adds thirteen stages,
// eight of them the modulo-3^exp_three reduction with two restoring steps per
// stage. A stall on the output side halts the back pipeline while the front
// keeps filling the queue.
module halton_pixel_sample_index_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel_x [31:0], pixel_y [63:32], sample_num [95:64]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [hpsi_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // sample_index [46:0], zero [47]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hpsi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hpsi_pkg::ADDR_W-1:0]     paddr,
    input  logic [hpsi_pkg::APB_W-1:0]      pwdata,
    output logic [hpsi_pkg::APB_W-1:0]      prdata,
    output logic                            pready
);
    import hpsi_pkg::*;

    t_cfg             w_cfg;
    logic             w_f_valid;
    logic             w_f_ready;
    t_item            w_f_item;
    logic             w_q_valid;
    logic             w_q_ready;
    t_item            w_q_item;
    logic [IDX_W-1:0] w_index;

    // configuration registers
    hpsi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // front: wrap and digit split
    hpsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_item  (w_f_item)
    );

    // decoupling queue
    hpsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    // back: offset arithmetic and final index
    hpsi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_item  (w_q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_index (w_index)
    );

    assign m_axis_tdata = OUT_DATA_W'(w_index);

endmodule

### tb/hpsi_checker.sv
`timescale 1ns / 1ps

// watches the config port and both streams, predicts each sample index and
// compares it with what comes out of the block
module hpsi_checker
    import hpsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    // pixel_x [31:0], pixel_y [63:32], sample_num [95:64]
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    // sample_index [46:0], zero [47]
    input  logic [OUT_DATA_W-1:0] i_out_data,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [ADDR_W-1:0]     i_paddr,
    input  logic [APB_W-1:0]      i_pwdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    // shadow copy of the block's registers
    logic [EXP2_W-1:0] exp_two_q;
    logic [EXP3_W-1:0] exp_three_q;
    logic [INV2_W-1:0] inv_two_q;
    logic [INV3_W-1:0] inv_three_q;

    logic [IDX_W-1:0] expected_index_q[$];
    int               fail_cnt = 0;

    // signed coordinate into [0, MAX_RESOLUTION)
    function automatic int wrap_coord(logic [PIX_W-1:0] raw);
        int v;
        int r;
        v = raw;
        r = v % MAX_RESOLUTION;
        if (r < 0) begin
            r += MAX_RESOLUTION;
        end
        return r;
    endfunction

    function automatic longint unsigned digit_reverse(int value, int base, int ndigits);
        longint unsigned acc;
        int              v;
        acc = 0;
        v   = value;
        for (int i = 0; i < ndigits; i++) begin
            acc = acc * base + v % base;
            v   = v / base;
        end
        return acc;
    endfunction

    function automatic logic [IDX_W-1:0] index_of_sample(logic [PIX_W-1:0]    px,
                                                         logic [PIX_W-1:0]    py,
                                                         logic [SAMPLE_W-1:0] sn);
        int              e3;
        longint unsigned scale2;
        longint unsigned scale3;
        longint unsigned stride;
        longint unsigned offset;
        longint unsigned r2;
        longint unsigned r3;
        // exp_three above five counts as five
        e3     = (exp_three_q > EXP3_MAX) ? EXP3_MAX : int'(exp_three_q);
        scale2 = 64'd1 << exp_two_q;
        scale3 = 1;
        for (int i = 0; i < e3; i++) begin
            scale3 = scale3 * 3;
        end
        stride = scale2 * scale3;
        offset = 0;
        // unit stride leaves the offset at zero
        if (stride > 1) begin
            r2     = digit_reverse(wrap_coord(px), 2, int'(exp_two_q));
            r3     = digit_reverse(wrap_coord(py), 3, e3);
            offset = (r2 * scale3 * inv_two_q + r3 * scale2 * inv_three_q) % stride;
        end
        return IDX_W'(offset + 64'(sn) * stride);
    endfunction

    always @(posedge i_clk) begin
        logic [IDX_W-1:0] want;
        logic [IDX_W-1:0] got;
        if (!i_rst_n) begin
            exp_two_q   <= '0;
            exp_three_q <= '0;
            inv_two_q   <= '0;
            inv_three_q <= '0;
            expected_index_q.delete();
        end else begin
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_EXP_TWO:   exp_two_q   <= i_pwdata[EXP2_W-1:0];
                    REG_EXP_THREE: exp_three_q <= i_pwdata[EXP3_W-1:0];
                    REG_INV_TWO:   inv_two_q   <= i_pwdata[INV2_W-1:0];
                    REG_INV_THREE: inv_three_q <= i_pwdata[INV3_W-1:0];
                    default: ;
                endcase
            end
            // input item accepted
            if (i_in_valid && i_in_ready) begin
                expected_index_q.push_back(index_of_sample(i_in_data[PIX_W-1:0],
                                                           i_in_data[2*PIX_W-1:PIX_W],
                                                           i_in_data[IN_DATA_W-1:2*PIX_W]));
            end
            // result item accepted
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[IDX_W-1:0];
                if (expected_index_q.size() == 0) begin
                    $display("%0t: unexpected sample_index, expected none, actual %0d",
                             $time, got);
                    fail_cnt++;
                end else begin
                    want = expected_index_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: sample_index mismatch, expected %0d, actual %0d",
                                 $time, want, got);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending    <= expected_index_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

### tb/halton_pixel_sample_index_top_tb.sv
`timescale 1ns / 1ps

module halton_pixel_sample_index_top_tb;
    import hpsi_pkg::*;

    localparam int IDLE_PCT       = 9;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int QUIET_LIMIT    = 4000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // pixel_x [31:0], pixel_y [63:32], sample_num [95:64]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // sample_index [46:0], zero [47]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [ADDR_W-1:0]     paddr         = '0;
    logic [APB_W-1:0]      pwdata        = '0;
    logic [APB_W-1:0]      prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit no_idle      = 1'b0;
    bit rx_hold_req  = 1'b0;

    halton_pixel_sample_index_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    hpsi_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // receiver side: random back-pressure, long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog: cycles with no traffic at all
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    task automatic apb_write(logic [REGSEL_W-1:0] idx, logic [APB_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(int e2, int e3, int inv2, int inv3);
        apb_write(REG_EXP_TWO, APB_W'(e2));
        apb_write(REG_EXP_THREE, APB_W'(e3));
        apb_write(REG_INV_TWO, APB_W'(inv2));
        apb_write(REG_INV_THREE, APB_W'(inv3));
    endtask

    function automatic int mod_inverse(int a, int m);
        for (int k = 1; k < m; k++) begin
            if ((a * k) % m == 1) begin
                return k;
            end
        end
        return 0;
    endfunction

    // exponents with the inverses that belong to them
    task automatic load_matched_config(int e2, int e3);
        int e3s;
        int m2;
        int m3;
        e3s = (e3 > EXP3_MAX) ? EXP3_MAX : e3;
        m2  = 1 << e2;
        m3  = 3 ** e3s;
        load_config(e2, e3, mod_inverse(m3 % m2, m2), mod_inverse(m2 % m3, m3));
    endtask

    task automatic send_item(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                             logic [SAMPLE_W-1:0] sn);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sn, py, px};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering and let every expected result come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] random_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return PIX_W'($urandom_range(0, 2 * MAX_RESOLUTION));
            2: return -PIX_W'($urandom_range(1, 3 * MAX_RESOLUTION));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'h0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 3))
            0, 1: return $urandom();
            2: return SAMPLE_W'($urandom_range(0, 64));
            default: return ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0;
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unit stride straight out of reset
        send_item(32'h0, 32'h0, 32'h0);
        send_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(32'h8000_0000, 32'h7fff_ffff, 32'd12345);
        drain();

        // widest exponents, coordinate and sample extremes
        load_matched_config(EXP2_MAX, EXP3_MAX);
        send_item(32'd0, 32'd0, 32'd0);
        send_item(32'd127, 32'd127, 32'd1);
        send_item(32'd128, 32'd128, 32'hffff_ffff);
        send_item(32'hffff_ffff, 32'hffff_ffff, 32'd0);
        send_item(-32'd128, -32'd129, 32'd7);
        send_item(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        send_item(32'h8000_0000, 32'h7fff_ffff, 32'd0);
        send_item(32'd1, 32'd0, 32'd0);
        send_item(32'd0, 32'd1, 32'd0);
        send_item(32'd64, 32'd81, 32'd3);
        send_item(32'd85, 32'd100, 32'd2);
        send_item(32'd42, 32'd26, 32'd5);
        drain();

        // digits above the exponents are dropped
        load_matched_config(2, 1);
        send_item(32'd127, 32'd127, 32'd0);
        send_item(32'd5, 32'd4, 32'd1);
        send_item(-32'd3, -32'd2, 32'd9);
        drain();

        // random phases, each with its own setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: load_config(EXP2_MAX, 7, 127, 255);
                1: load_config(0, 0, $urandom_range(1, 127), $urandom_range(1, 255));
                2: load_matched_config(4, 3);
                3: load_matched_config(EXP2_MAX, EXP3_MAX);
                4: load_matched_config(1, 0);
                5: load_matched_config(0, EXP3_MAX);
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        load_config($urandom_range(0, 7), $urandom_range(0, 7),
                                    $urandom_range(0, 127), $urandom_range(0, 255));
                    end else begin
                        load_matched_config($urandom_range(0, 7), $urandom_range(0, 7));
                    end
                end
            endcase
            rx_hold_req = (p == 2);
            no_idle     = (p == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(random_coord(), random_coord(), random_sample());
            end
            drain();
            no_idle = 1'b0;
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
